// ===== rtl/core/pnc_pkg.sv =====
`timescale 1ns / 1ps

package pnc_pkg;

	// Width of a colour distance; the largest distance is 3570.
	localparam int DIST_W = 12;
	localparam int COLOUR_W = 32;

	// Radius of an entry that has no neighbour, above any distance.
	localparam logic [DIST_W-1:0] RADIUS_NONE = 12'hFFF;
	// Starting best distance of a match scan, above any distance.
	localparam logic [DIST_W-1:0] DIST_NONE = 12'hFFF;

	typedef enum logic [1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_MATCH  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RADIUS,
		ST_RESULT
	} state_t;

	// Strobes from the sequencer to the palette store.
	typedef struct packed {
		logic rd_en;
		logic pal_we;
		logic rad_we;
	} mem_ctrl_t;

endpackage

// ===== rtl/core/pnc_dist.sv =====
`timescale 1ns / 1ps

// Weighted colour distance |db| + 10*|dg| + 3*|dr| built from shifts and adds.
module pnc_dist (
	input  logic [pnc_pkg::COLOUR_W-1:0] colour_a,
	input  logic [pnc_pkg::COLOUR_W-1:0] colour_b,
	output logic [pnc_pkg::DIST_W-1:0]   distance
);

	logic [7:0] db;
	logic [7:0] dg;
	logic [7:0] dr;
	logic [pnc_pkg::DIST_W-1:0] dg_ext;
	logic [pnc_pkg::DIST_W-1:0] dr_ext;

	always_comb begin
		db = (colour_a[31:24] > colour_b[31:24]) ? colour_a[31:24] - colour_b[31:24]
		                                         : colour_b[31:24] - colour_a[31:24];
		dg = (colour_a[23:16] > colour_b[23:16]) ? colour_a[23:16] - colour_b[23:16]
		                                         : colour_b[23:16] - colour_a[23:16];
		dr = (colour_a[15:8] > colour_b[15:8]) ? colour_a[15:8] - colour_b[15:8]
		                                       : colour_b[15:8] - colour_a[15:8];
		dg_ext = {4'd0, dg};
		dr_ext = {4'd0, dr};
		distance = {4'd0, db} + (dg_ext << 3) + (dg_ext << 1) +
		           (dr_ext << 1) + dr_ext;
	end

endmodule

// ===== rtl/core/pnc_mem.sv =====
`timescale 1ns / 1ps

// Palette colour and radius store: one write port per array, one shared
// read address with registered read data.
module pnc_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                        clk,
	input  pnc_pkg::mem_ctrl_t          ctrl,
	input  logic [AW-1:0]               rd_addr,
	input  logic [AW-1:0]               pal_waddr,
	input  logic [pnc_pkg::COLOUR_W-1:0] pal_wdata,
	input  logic [AW-1:0]               rad_waddr,
	input  logic [pnc_pkg::DIST_W-1:0]   rad_wdata,
	output logic [pnc_pkg::COLOUR_W-1:0] rd_colour,
	output logic [pnc_pkg::DIST_W-1:0]   rd_radius
);

	logic [pnc_pkg::COLOUR_W-1:0] pal_mem [DEPTH];
	logic [pnc_pkg::DIST_W-1:0]   rad_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctrl.pal_we) begin
			pal_mem[pal_waddr] <= pal_wdata;
		end
		if (ctrl.rd_en) begin
			rd_colour <= pal_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rad_we) begin
			rad_mem[rad_waddr] <= rad_wdata;
		end
		if (ctrl.rd_en) begin
			rd_radius <= rad_mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/palette_nearest_colour_match.sv =====
`timescale 1ns / 1ps

// Sequencing: a clear or an ignored request frees the input in the cycle after its transfer;
// an append holds s_tready low through its scan (ST_SCAN) and radius write (ST_RADIUS).
// A match scans the entries in ST_SCAN, ending at an early exit, and raises m_tvalid from
// ST_RESULT, which it enters directly on an empty palette; receiver stalls hold it there.
// Throughput: one request at a time, bounded by the single memory read port (one entry/cycle).
// Reset (arst_n low, asynchronous) empties the palette and drops any pending result.

module palette_nearest_colour_match #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] colour_word
	input  logic [2:0]  s_tuser,   // [1:0] req_type, [2] want_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] match_value, [39:32] match_index
	output logic [0:0]  m_tuser    // [0] palette_empty
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// Sequencer state and the request being served.
	pnc_pkg::state_t state_q, state_d;
	pnc_pkg::req_t   op_q;
	pnc_pkg::req_t   req_in;
	logic [31:0]     query_q;
	logic            want_q;
	logic            empty_q;

	// Fill count of the palette and the scan address counter. Palette memories are
	// not cleared; entries at or beyond the fill count are never read.
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;

	// Read-data stage: the entry index whose data the memory returns this cycle.
	logic          valid_s1;
	logic [AW-1:0] idx_s1;

	// Running results of a scan.
	logic [pnc_pkg::DIST_W-1:0] best_dist_q;
	logic [AW-1:0]              best_idx_q;
	logic [31:0]                best_colour_q;
	logic [pnc_pkg::DIST_W-1:0] slot_rad_q;

	// Output register.
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic        m_empty_q;

	// Memory interface.
	pnc_pkg::mem_ctrl_t         mem_ctrl;
	logic [AW-1:0]              rad_waddr;
	logic [pnc_pkg::DIST_W-1:0] rad_wdata;
	logic [31:0]                rd_colour;
	logic [pnc_pkg::DIST_W-1:0] rd_radius;

	// Shared distance unit and the decisions taken on its result.
	logic [pnc_pkg::DIST_W-1:0] distance;
	logic [pnc_pkg::DIST_W-1:0] half;
	logic                       s_xfer;
	logic                       palette_full;
	logic                       scan_active;
	logic                       scan_done;
	logic                       closer;
	logic                       early_exit;
	logic                       out_free;
	logic [31:0]                idx_ext;
	logic [31:0]                result_value;

	assign req_in       = pnc_pkg::req_t'(s_tuser[1:0]);
	assign s_xfer       = s_tvalid && s_tready;
	assign palette_full = (count_q == CW'(MAX_ENTRIES));
	assign scan_active  = (state_q == pnc_pkg::ST_SCAN);
	assign half         = distance >> 1;
	assign closer       = scan_active && valid_s1 && (distance < best_dist_q);
	// A match stops at the first entry that beats the best so far and lies
	// inside that entry's own exit radius.
	assign early_exit   = closer && (op_q == pnc_pkg::REQ_MATCH) && (distance < rd_radius);
	assign scan_done    = scan_active && (issue_q == count_q) && !valid_s1;
	assign out_free     = !m_tvalid_q || m_tready;
	assign idx_ext      = 32'(best_idx_q);
	assign result_value = empty_q ? 32'd0 : (want_q ? idx_ext : best_colour_q);

	pnc_dist u_dist (
		.colour_a (query_q),
		.colour_b (rd_colour),
		.distance (distance)
	);

	pnc_mem #(
		.DEPTH (MAX_ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.ctrl      (mem_ctrl),
		.rd_addr   (issue_q[AW-1:0]),
		.pal_waddr (count_q[AW-1:0]),
		.pal_wdata (s_tdata),
		.rad_waddr (rad_waddr),
		.rad_wdata (rad_wdata),
		.rd_colour (rd_colour),
		.rd_radius (rd_radius)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pnc_pkg::ST_IDLE: begin
				if (s_xfer) begin
					if (req_in == pnc_pkg::REQ_MATCH) begin
						state_d = (count_q == '0) ? pnc_pkg::ST_RESULT : pnc_pkg::ST_SCAN;
					end else if (req_in == pnc_pkg::REQ_APPEND && !palette_full) begin
						state_d = pnc_pkg::ST_SCAN;
					end
				end
			end
			pnc_pkg::ST_SCAN: begin
				if (early_exit) begin
					state_d = pnc_pkg::ST_RESULT;
				end else if (scan_done) begin
					state_d = (op_q == pnc_pkg::REQ_APPEND) ? pnc_pkg::ST_RADIUS
					                                        : pnc_pkg::ST_RESULT;
				end
			end
			pnc_pkg::ST_RADIUS: begin
				state_d = pnc_pkg::ST_IDLE;
			end
			pnc_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = pnc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pnc_pkg::ST_IDLE;
			end
		endcase
	end

	// Output and memory strobe logic.
	always_comb begin
		s_tready        = 1'b0;
		mem_ctrl.rd_en  = 1'b0;
		mem_ctrl.pal_we = 1'b0;
		mem_ctrl.rad_we = 1'b0;
		rad_waddr       = idx_s1;
		rad_wdata       = half;
		case (state_q)
			pnc_pkg::ST_IDLE: begin
				s_tready        = 1'b1;
				mem_ctrl.pal_we = s_tvalid && (req_in == pnc_pkg::REQ_APPEND) && !palette_full;
			end
			pnc_pkg::ST_SCAN: begin
				mem_ctrl.rd_en = (issue_q != count_q);
				// During an append, pull an earlier entry's radius in to half
				// its distance from the new entry.
				mem_ctrl.rad_we = valid_s1 && (op_q == pnc_pkg::REQ_APPEND) &&
				                  (half < rd_radius);
			end
			pnc_pkg::ST_RADIUS: begin
				mem_ctrl.rad_we = 1'b1;
				rad_waddr       = count_q[AW-1:0];
				rad_wdata       = slot_rad_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pnc_pkg::ST_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= mem_ctrl.rd_en;
			if (s_xfer) begin
				issue_q <= '0;
				if (req_in == pnc_pkg::REQ_CLEAR) begin
					count_q <= '0;
				end
			end else if (mem_ctrl.rd_en) begin
				issue_q <= issue_q + 1'b1;
			end
			if (state_q == pnc_pkg::ST_RADIUS) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == pnc_pkg::ST_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		if (s_xfer) begin
			op_q        <= req_in;
			query_q     <= s_tdata;
			want_q      <= s_tuser[2];
			empty_q     <= (count_q == '0);
			best_dist_q <= pnc_pkg::DIST_NONE;
			best_idx_q  <= '0;
			slot_rad_q  <= pnc_pkg::RADIUS_NONE;
		end
		if (closer) begin
			best_dist_q   <= distance;
			best_idx_q    <= idx_s1;
			best_colour_q <= rd_colour;
		end
		if (scan_active && valid_s1 && half < slot_rad_q) begin
			slot_rad_q <= half;
		end
		if (state_q == pnc_pkg::ST_RESULT && out_free) begin
			m_tdata_q <= {idx_ext[7:0], result_value};
			m_empty_q <= empty_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_empty_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("palette fill count above capacity");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q <= count_q)
		else $error("scan address beyond fill count");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pnc_pkg::ST_RADIUS |=> count_q == $past(count_q) + 1'b1)
		else $error("append did not grow the palette by one");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 40'd0)
		else $error("empty palette result carries nonzero data");

	a_scan_only_match_or_append: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pnc_pkg::ST_SCAN |->
			op_q == pnc_pkg::REQ_MATCH || op_q == pnc_pkg::REQ_APPEND)
		else $error("scan running for a request that has none");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	// The block is built at its default depth, so the palette model uses the same size.
	localparam int PALETTE_DEPTH = 256;
	// Requests that do something, counted over the directed and random parts together.
	localparam int REQUEST_TARGET = 1300;
	// The fill-to-capacity episode starts once this many requests have gone through.
	localparam int FULL_FILL_AT = 450;
	// An append into the last free slot keeps the block busy while it scans every stored entry,
	// so this covers any request that was still in flight when the last match result came back.
	localparam int DRAIN_CYCLES = PALETTE_DEPTH + 64;
	localparam int MAX_REPORTS = 10;

	// One match result as it travels on the master side.
	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  index;
		logic        empty;
	} match_result_t;

	// One row of the directed table. Rows with known_result set carry a result that can
	// be read straight off the request; every other match row is checked by the model.
	typedef struct packed {
		pnc_pkg::req_t req;
		logic [31:0]   word;
		logic          want_index;
		logic          known_result;
		logic [31:0]   res_value;
		logic [7:0]    res_index;
		logic          res_empty;
	} stim_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;    // [31:0] colour_word
	logic [2:0]  s_tuser = '0;    // [1:0] req_type, [2] want_index
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [31:0] match_value, [39:32] match_index
	logic [0:0]  m_tuser;         // [0] palette_empty

	palette_nearest_colour_match #(
		.MAX_ENTRIES(PALETTE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Palette model: colour words, early-exit radii and the fill count.
	logic [31:0]   pal_words [PALETTE_DEPTH];
	logic [11:0]   pal_radius [PALETTE_DEPTH];
	int unsigned   pal_fill = 0;
	match_result_t pending_matches [$];

	// Idle rates of the two sides, in percent of cycles, changed phase by phase.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	int requests_done = 0;
	int matches_sent = 0;
	int empty_matches = 0;
	int early_exits = 0;
	int dropped_appends = 0;
	int largest_fill = 0;
	int results_seen = 0;
	int mismatches = 0;

	// The directed part: empty palette after reset, the two colour extremes, the unused
	// request code, bits 7:0 being ignored, a duplicate entry whose radius drops to zero
	// so the tie goes to the first entry, a clear, and early exits on a small palette.
	stim_row_t directed_rows [20] = '{
		'{pnc_pkg::REQ_MATCH,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 8'h00, 1'b1},
		'{pnc_pkg::REQ_NONE,   32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_APPEND, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_APPEND, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 8'h01, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 8'h00, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h7F7F_7F7F, 1'b1, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h8080_8000, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 8'h00, 1'b1},
		'{pnc_pkg::REQ_APPEND, 32'h1020_30AB, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h1020_30CD, 1'b0, 1'b1, 32'h1020_30AB, 8'h00, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 8'h00, 1'b0},
		'{pnc_pkg::REQ_APPEND, 32'h1020_3000, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h1020_3055, 1'b1, 1'b1, 32'h0000_0000, 8'h00, 1'b0},
		'{pnc_pkg::REQ_APPEND, 32'h3040_5060, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'h2F3F_4F00, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_APPEND, 32'hAAAA_AAAA, 1'b1, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_NONE,   32'h0000_0000, 1'b0, 1'b0, 32'h0, 8'h0, 1'b0},
		'{pnc_pkg::REQ_MATCH,  32'hFF00_0000, 1'b1, 1'b0, 32'h0, 8'h0, 1'b0}
	};

	// Weighted distance of the colour bytes; bits 7:0 play no part.
	function automatic int unsigned colour_distance_of(logic [31:0] a, logic [31:0] b);
		int unsigned db, dg, dr;
		db = (a[31:24] > b[31:24]) ? a[31:24] - b[31:24] : b[31:24] - a[31:24];
		dg = (a[23:16] > b[23:16]) ? a[23:16] - b[23:16] : b[23:16] - a[23:16];
		dr = (a[15:8] > b[15:8]) ? a[15:8] - b[15:8] : b[15:8] - a[15:8];
		return db + 10 * dg + 3 * dr;
	endfunction

	// A colour a few steps away from the given one in each byte, with a random low byte.
	// Clustered entries give small radii, so the early exit is hit often.
	function automatic logic [31:0] jitter_colour(logic [31:0] w);
		logic [31:0] r;
		r[31:24] = w[31:24] + 8'($urandom_range(0, 6)) - 8'd3;
		r[23:16] = w[23:16] + 8'($urandom_range(0, 6)) - 8'd3;
		r[15:8] = w[15:8] + 8'($urandom_range(0, 6)) - 8'd3;
		r[7:0] = 8'($urandom());
		return r;
	endfunction

	// Query colours: fully random, near the episode's base colour, or near a stored entry.
	function automatic logic [31:0] pick_query(logic [31:0] base);
		int unsigned pick;
		pick = $urandom_range(0, 3);
		if (pick == 0 || (pick >= 2 && pal_fill == 0))
			return $urandom();
		if (pick == 1)
			return jitter_colour(base);
		return jitter_colour(pal_words[$urandom_range(0, pal_fill - 1)]);
	endfunction

	// Applies one accepted request to the palette model. A match queues its result,
	// or the table's result where the row gives one. acted is low for requests that
	// the block drops: the unused code and appends into a full palette.
	task automatic predict_palette_request(input pnc_pkg::req_t req, input logic [31:0] word,
			input logic want_index, input bit known, input match_result_t known_res,
			output bit acted);
		int unsigned k, half, d, best, best_dist;
		match_result_t res;
		acted = 1'b1;
		case (req)
			pnc_pkg::REQ_CLEAR: begin
				pal_fill = 0;
			end
			pnc_pkg::REQ_APPEND: begin
				if (pal_fill >= PALETTE_DEPTH) begin
					acted = 1'b0;
					dropped_appends++;
				end else begin
					pal_words[pal_fill] = word;
					pal_radius[pal_fill] = pnc_pkg::RADIUS_NONE;
					// Half of each pair distance narrows both radii of the pair.
					for (k = 0; k < pal_fill; k++) begin
						half = colour_distance_of(pal_words[k], word) / 2;
						if (half < pal_radius[pal_fill])
							pal_radius[pal_fill] = half[11:0];
						if (half < pal_radius[k])
							pal_radius[k] = half[11:0];
					end
					pal_fill++;
					if (pal_fill > largest_fill)
						largest_fill = pal_fill;
				end
			end
			pnc_pkg::REQ_MATCH: begin
				if (pal_fill == 0) begin
					res = '{32'd0, 8'd0, 1'b1};
					empty_matches++;
				end else begin
					best = 0;
					best_dist = pnc_pkg::DIST_NONE;
					// The first entry that improves on the best and sits inside its
					// own radius ends the scan; otherwise the first minimum wins.
					for (k = 0; k < pal_fill; k++) begin
						d = colour_distance_of(word, pal_words[k]);
						if (d < best_dist) begin
							best = k;
							best_dist = d;
							if (d < pal_radius[k]) begin
								early_exits++;
								break;
							end
						end
					end
					res.value = want_index ? 32'(best) : pal_words[best];
					res.index = best[7:0];
					res.empty = 1'b0;
				end
				matches_sent++;
				pending_matches.push_back(known ? known_res : res);
			end
			default: begin
				acted = 1'b0;
			end
		endcase
	endtask

	// Offers one request on the slave side, with random idle cycles ahead of it, and
	// feeds it to the model at the edge where the transfer happens. s_tvalid stays high
	// when the next request follows without a gap.
	task automatic send_request(input pnc_pkg::req_t req, input logic [31:0] word,
			input logic want_index, input bit known = 1'b0,
			input match_result_t known_res = '0);
		bit acted;
		// Four idling phases in turn: none, sender idle, receiver stalling, both.
		case (requests_done * 4 / REQUEST_TARGET)
			0: begin send_idle_pct = 0; recv_stall_pct = 0; end
			1: begin send_idle_pct = 62; recv_stall_pct = 0; end
			2: begin send_idle_pct = 0; recv_stall_pct = 62; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= {want_index, req};
		do
			@(posedge clk);
		while (!s_tready);
		predict_palette_request(req, word, want_index, known, known_res, acted);
		if (acted)
			requests_done++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	// Every result transfer is checked against the oldest queued expectation.
	always @(posedge clk) begin
		match_result_t want_res;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_matches.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with none expected: value %h index %h empty %b",
						$realtime, m_tdata[31:0], m_tdata[39:32], m_tuser[0]);
			end else begin
				want_res = pending_matches.pop_front();
				if (m_tdata[31:0] !== want_res.value || m_tdata[39:32] !== want_res.index ||
						m_tuser[0] !== want_res.empty) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: result %0d: expected value %h index %h empty %b,",
							$realtime, results_seen, want_res.value, want_res.index,
							want_res.empty);
						$display("    got value %h index %h empty %b",
							m_tdata[31:0], m_tdata[39:32], m_tuser[0]);
					end
				end
			end
		end
	end

	initial begin
		int unsigned i, n, m;
		logic [31:0] base, word;
		bit full_fill_done;
		full_fill_done = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed_rows); i++)
			send_request(directed_rows[i].req, directed_rows[i].word,
				directed_rows[i].want_index, directed_rows[i].known_result,
				'{directed_rows[i].res_value, directed_rows[i].res_index,
				directed_rows[i].res_empty});

		// Random episodes: mostly a clear, a run of appends around a base colour and a
		// few matches near the stored entries, with stray requests mixed in. Once in the
		// run the palette is filled to capacity and pushed past it.
		while (requests_done < REQUEST_TARGET) begin
			base = $urandom();
			if (!full_fill_done && requests_done >= FULL_FILL_AT) begin
				full_fill_done = 1'b1;
				send_request(pnc_pkg::REQ_CLEAR, $urandom(), 1'($urandom()));
				for (i = 0; i < PALETTE_DEPTH + 4; i++) begin
					if (i % 7 == 3)
						word = pal_words[$urandom_range(0, pal_fill - 1)];
					else if (i % 2 == 0)
						word = jitter_colour(base);
					else
						word = $urandom();
					send_request(pnc_pkg::REQ_APPEND, word, 1'($urandom()));
				end
				repeat (12)
					send_request(pnc_pkg::REQ_MATCH, pick_query(base), 1'($urandom()));
			end else begin
				if ($urandom_range(0, 9) < 8)
					send_request(pnc_pkg::REQ_CLEAR, $urandom(), 1'($urandom()));
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48)
				                                : $urandom_range(1, 12);
				for (i = 0; i < n; i++) begin
					// Noise: the unused code or a match on a half-built palette.
					if ($urandom_range(0, 14) == 0)
						send_request(($urandom_range(0, 1) == 0) ? pnc_pkg::REQ_NONE
							: pnc_pkg::REQ_MATCH, $urandom(), 1'($urandom()));
					word = ($urandom_range(0, 2) == 0) ? $urandom() : jitter_colour(base);
					send_request(pnc_pkg::REQ_APPEND, word, 1'($urandom()));
				end
				m = $urandom_range(2, 8);
				for (i = 0; i < m; i++)
					send_request(pnc_pkg::REQ_MATCH, pick_query(base), 1'($urandom()));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests with %0d match results checked",
			requests_done, results_seen);
		$display("(%0d on an empty palette, %0d early exits); palette grew to %0d entries,",
			empty_matches, early_exits, largest_fill);
		$display("and %0d appends on a full palette were dropped.", dropped_appends);
		if (mismatches == 0 && pending_matches.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_matches.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Far beyond the slowest correct run, in which every request scans a full palette.
	initial begin
		#40_000_000;
		$display("Timed out with %0d results outstanding", pending_matches.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
